### rtl/qmsg_pkg.sv
`timescale 1ns / 1ps

package qmsg_pkg;

   // fixed field widths of the channels
   localparam int MAX_MOTORS = 4;
   localparam int DUR_W      = 16;
   localparam int SPEED_W    = 32;
   localparam int LEVEL_W    = 5;

   // defaults for the top level parameters
   localparam int DEF_MOTOR_COUNT = 4;
   localparam int DEF_QUEUE_DEPTH = 16;

   // start level after reset
   localparam logic [LEVEL_W-1:0] START_LEVEL_RESET = 5'd4;

   // request operation codes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // classified request handed from the front to the back
   typedef struct packed {
      op_type                                 op;
      logic [DUR_W-1:0]                       duration;
      logic [MAX_MOTORS-1:0][SPEED_W-1:0]     speeds;
   } cmd_type;

   // one result
   typedef struct packed {
      logic                    push_accepted;
      logic [MAX_MOTORS-1:0]   step_pins;
      logic [MAX_MOTORS-1:0]   motor_enables;
      logic [LEVEL_W-1:0]      queue_level;
      logic                    streaming;
   } rsp_type;

endpackage

### rtl/qmsg_ifs.sv
`timescale 1ns / 1ps

// request channel
interface qmsg_req_if import qmsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [DUR_W-1:0]   frame_duration;
   logic [SPEED_W-1:0] speed_zero;
   logic [SPEED_W-1:0] speed_one;
   logic [SPEED_W-1:0] speed_two;
   logic [SPEED_W-1:0] speed_three;

   modport source (
      output valid, operation, frame_duration,
      output speed_zero, speed_one, speed_two, speed_three,
      input  ready
   );
   modport sink (
      input  valid, operation, frame_duration,
      input  speed_zero, speed_one, speed_two, speed_three,
      output ready
   );
endinterface

// result channel
interface qmsg_rsp_if import qmsg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  push_accepted;
   logic [MAX_MOTORS-1:0] step_pins;
   logic [MAX_MOTORS-1:0] motor_enables;
   logic [LEVEL_W-1:0]    queue_level;
   logic                  streaming;

   modport source (
      output valid, push_accepted, step_pins, motor_enables, queue_level, streaming,
      input  ready
   );
   modport sink (
      input  valid, push_accepted, step_pins, motor_enables, queue_level, streaming,
      output ready
   );
endinterface

// control register write channel
interface qmsg_csr_if import qmsg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] start_level;

   modport source (output valid, start_level, input ready);
   modport sink (input valid, start_level, output ready);
endinterface

### rtl/qmsg_front.sv
`timescale 1ns / 1ps

module qmsg_front import qmsg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qmsg_req_if.sink     req_bus,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  logic         cmd_pop
);

   localparam int SLOTS = 2;

   cmd_type          slot_ff [SLOTS];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             take;
   cmd_type          new_cmd;

   // decode the request into a command
   always_comb begin
      new_cmd.op       = op_type'(req_bus.operation);
      new_cmd.duration = req_bus.frame_duration;
      new_cmd.speeds   = {req_bus.speed_three, req_bus.speed_two,
                          req_bus.speed_one, req_bus.speed_zero};
   end

   assign req_bus.ready = (count_ff != 2'(SLOTS));
   assign take          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (count_ff != 2'd0);
   assign cmd_data      = slot_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = take ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(take) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue slots
   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/qmsg_back.sv
`timescale 1ns / 1ps

module qmsg_back import qmsg_pkg::*; #(
   parameter int MOTOR_COUNT = DEF_MOTOR_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LEVEL_W-1:0] start_level,
   input  logic               cmd_valid,
   input  cmd_type            cmd_data,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [DUR_W-1:0]                    duration;
      logic [MOTOR_COUNT-1:0][SPEED_W-1:0] speeds;
   } frame_type;

   frame_type               frame_mem [QUEUE_DEPTH];
   frame_type               head_ff;
   frame_type               new_frame;
   logic                    mem_we;

   logic [SPEED_W-1:0]      phase_ff [MOTOR_COUNT];
   logic [SPEED_W-1:0]      phase_in [MOTOR_COUNT];
   logic [SPEED_W-1:0]      speed_ff [MOTOR_COUNT];
   logic [SPEED_W-1:0]      speed_in [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0]  steps_ff, steps_in;
   logic [MOTOR_COUNT-1:0]  enables;
   logic [DUR_W-1:0]        ticks_ff, ticks_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    stream_ff, stream_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    fire;
   logic                    accepted;

   assign fire      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop   = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame as written into the store
   always_comb begin
      new_frame.duration = cmd_data.duration;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         new_frame.speeds[m] = cmd_data.speeds[m];
      end
   end

   // execute one command
   always_comb begin
      logic [SPEED_W:0] sum;
      logic             load;

      sum       = '0;
      load      = 1'b0;
      mem_we    = 1'b0;
      accepted  = 1'b0;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      stream_in = stream_ff;
      ticks_in  = ticks_ff;
      steps_in  = steps_ff;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         phase_in[m] = phase_ff[m];
         speed_in[m] = speed_ff[m];
      end

      if (fire) begin
         unique case (cmd_data.op)
            OP_PUSH: begin
               if (count_ff != FULL_CNT) begin
                  mem_we    = 1'b1;
                  accepted  = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_TICK: begin
               // frame ran out: load the next one, wait for the start level, or stop
               if (ticks_ff == '0) begin
                  if (count_ff == '0) begin
                     for (int m = 0; m < MOTOR_COUNT; m++) speed_in[m] = '0;
                     stream_in = 1'b0;
                  end else if (!stream_ff && (CMP_W'(count_ff) < CMP_W'(start_level))) begin
                     for (int m = 0; m < MOTOR_COUNT; m++) speed_in[m] = '0;
                  end else begin
                     load      = 1'b1;
                     stream_in = 1'b1;
                     for (int m = 0; m < MOTOR_COUNT; m++) speed_in[m] = head_ff.speeds[m];
                     rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
                     count_in  = count_ff - 1'b1;
                  end
               end

               // remaining ticks after this one
               if (load) begin
                  ticks_in = (head_ff.duration == '0) ? '0 : head_ff.duration - 1'b1;
               end else if (ticks_ff != '0) begin
                  ticks_in = ticks_ff - 1'b1;
               end

               // phase accumulate, carry out gives a step
               for (int m = 0; m < MOTOR_COUNT; m++) begin
                  if (speed_in[m] != '0) begin
                     sum         = {1'b0, phase_ff[m]} + {1'b0, speed_in[m]};
                     phase_in[m] = sum[SPEED_W-1:0];
                     steps_in[m] = sum[SPEED_W];
                  end else begin
                     steps_in[m] = 1'b0;
                  end
               end
            end
         endcase
      end

      for (int m = 0; m < MOTOR_COUNT; m++) begin
         enables[m] = (speed_in[m] != '0);
      end
   end

   // result register
   always_comb begin
      rsp_data_in.push_accepted = accepted;
      rsp_data_in.step_pins     = MAX_MOTORS'(steps_in);
      rsp_data_in.motor_enables = MAX_MOTORS'(enables);
      rsp_data_in.queue_level   = LEVEL_W'(count_in);
      rsp_data_in.streaming     = stream_in;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            phase_ff[m] <= '0;
            speed_ff[m] <= '0;
         end
         steps_ff     <= '0;
         ticks_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         stream_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            phase_ff[m] <= phase_in[m];
            speed_ff[m] <= speed_in[m];
         end
         steps_ff     <= steps_in;
         ticks_ff     <= ticks_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         stream_ff    <= stream_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // frame store, head entry read ahead with write bypass
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_ptr_ff] <= new_frame;
      end
      if (mem_we && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= new_frame;
      end else begin
         head_ff <= frame_mem[rd_ptr_in];
      end
   end

endmodule

### rtl/queued_multi_stepper_step_generator.sv
`timescale 1ns / 1ps

// channel   modport  handshake     payload
// req_bus   sink     valid/ready   operation, frame_duration, speed_zero..speed_three
// rsp_bus   source   valid/ready   push_accepted, step_pins, motor_enables,
//                                  queue_level, streaming
// csr_bus   sink     valid/ready   start_level (always ready)
//
// one request per cycle sustained while rsp_bus is not stalled; each request is
// registered in a front queue slot, then its result in the result register of the back
// the execute stage reads its frame from the frame store head register
// reset is synchronous and takes effect at once; no clearing pass
// a stalled result holds the back, the two-entry front queue absorbs requests
// until it fills, then req_bus.ready drops

module queued_multi_stepper_step_generator import qmsg_pkg::*; #(
   parameter int MOTOR_COUNT = DEF_MOTOR_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   qmsg_req_if.sink    req_bus,
   qmsg_rsp_if.source  rsp_bus,
   qmsg_csr_if.sink    csr_bus
);

   logic               start_level_ff;
   logic [LEVEL_W-1:0] start_level_q_ff;
   logic               cmd_valid;
   logic               cmd_pop;
   cmd_type            cmd_data;
   logic               rsp_valid;
   rsp_type            rsp_data;

   // start level register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_level_q_ff <= START_LEVEL_RESET;
         start_level_ff   <= 1'b0;
      end else begin
         start_level_ff <= csr_bus.valid;
         if (csr_bus.valid) begin
            start_level_q_ff <= csr_bus.start_level;
         end
      end
   end

   // accept and classify requests
   qmsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // frame queue, phase accumulators and result register
   qmsg_back #(
      .MOTOR_COUNT (MOTOR_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .start_level (start_level_q_ff),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_data    (rsp_data)
   );

   // result channel
   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.push_accepted = rsp_data.push_accepted;
   assign rsp_bus.step_pins     = rsp_data.step_pins;
   assign rsp_bus.motor_enables = rsp_data.motor_enables;
   assign rsp_bus.queue_level   = rsp_data.queue_level;
   assign rsp_bus.streaming     = rsp_data.streaming;

   // a step only comes from a running motor
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.step_pins & ~rsp_bus.motor_enables) == '0))
      else $error("step pin raised on a stopped motor");

   // motors run only while streaming
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.streaming) |-> (rsp_bus.motor_enables == '0))
      else $error("motor enabled outside streaming");

   // the back only takes a command that the front offers
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty front queue");

   // a result that waits is not replaced
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bus.ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("pending result lost");

   // start level register takes each written value
   assert property (@(posedge clock) disable iff (reset)
      start_level_ff |-> (start_level_q_ff == $past(csr_bus.start_level)))
      else $error("start level not updated by write");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import qmsg_pkg::*;

   localparam int MOTORS      = DEF_MOTOR_COUNT;
   localparam int QDEPTH      = DEF_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 4_000_000;

   // one row of stimulus, with an optional hand-typed result
   typedef struct {
      cmd_type cmd;
      bit      pinned;
      rsp_type want;
   } stim_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SLOW
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   qmsg_req_if req_bus ();
   qmsg_rsp_if rsp_bus ();
   qmsg_csr_if csr_bus ();

   queued_multi_stepper_step_generator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // step generator state as the testbench sees it
   cmd_type              frame_queue [QDEPTH];
   logic [SPEED_W-1:0]   phase_acc [MAX_MOTORS];
   logic [SPEED_W-1:0]   live_speed [MAX_MOTORS];
   logic [MAX_MOTORS-1:0] pin_levels = '0;
   int                   frame_ticks_left = 0;
   int                   head_ptr = 0;
   int                   tail_ptr = 0;
   int                   queued_frames = 0;
   bit                   stream_on = 1'b0;
   logic [LEVEL_W-1:0]   start_level_q = START_LEVEL_RESET;

   rsp_type expected_results [$];

   int error_count     = 0;
   int results_checked = 0;
   int pushes_sent     = 0;
   int pushes_rejected = 0;
   int ticks_sent      = 0;
   int step_pulses     = 0;
   int level_writes    = 0;
   int burst_left      = 0;
   int cycle_count     = 0;

   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_mode_left = 0;

   // advance the step generator by one request and return its result
   function automatic rsp_type predict_step_result(input cmd_type c);
      rsp_type          res;
      logic [SPEED_W:0] sum;
      int               m;
      res = '0;
      if (c.op == OP_PUSH) begin
         if (queued_frames < QDEPTH) begin
            frame_queue[tail_ptr] = c;
            tail_ptr = (tail_ptr + 1) % QDEPTH;
            queued_frames++;
            res.push_accepted = 1'b1;
         end else begin
            pushes_rejected++;
         end
      end else begin
         // load the next frame once the current one has run out
         if (frame_ticks_left == 0) begin
            if (queued_frames == 0)
               stream_on = 1'b0;
            if (queued_frames != 0 && (stream_on || queued_frames >= start_level_q)) begin
               stream_on = 1'b1;
               for (m = 0; m < MAX_MOTORS; m++)
                  live_speed[m] = (m < MOTORS) ? frame_queue[head_ptr].speeds[m] : '0;
               frame_ticks_left = (frame_queue[head_ptr].duration == 0) ? 1 :
                                  frame_queue[head_ptr].duration;
               head_ptr = (head_ptr + 1) % QDEPTH;
               queued_frames--;
            end else begin
               for (m = 0; m < MAX_MOTORS; m++)
                  live_speed[m] = '0;
            end
         end
         // phase accumulation, carry out pulses the pin
         pin_levels = '0;
         for (m = 0; m < MOTORS; m++) begin
            if (live_speed[m] != 0) begin
               sum = {1'b0, phase_acc[m]} + {1'b0, live_speed[m]};
               phase_acc[m] = sum[SPEED_W-1:0];
               pin_levels[m] = sum[SPEED_W];
            end
         end
         if (frame_ticks_left != 0)
            frame_ticks_left--;
      end
      res.step_pins = pin_levels;
      for (m = 0; m < MOTORS; m++)
         res.motor_enables[m] = (live_speed[m] != 0);
      res.queue_level = LEVEL_W'(queued_frames);
      res.streaming   = stream_on;
      return res;
   endfunction

   function automatic logic [SPEED_W-1:0] random_speed();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2: return '1;
         3: return $urandom_range(1, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type make_row(input op_type op, input logic [DUR_W-1:0] dur,
                                             input logic [SPEED_W-1:0] s0,
                                             input logic [SPEED_W-1:0] s1,
                                             input logic [SPEED_W-1:0] s2,
                                             input logic [SPEED_W-1:0] s3);
      stim_row_type r;
      r.cmd.op        = op;
      r.cmd.duration  = dur;
      r.cmd.speeds[0] = s0;
      r.cmd.speeds[1] = s1;
      r.cmd.speeds[2] = s2;
      r.cmd.speeds[3] = s3;
      r.pinned        = 1'b0;
      r.want          = '0;
      return r;
   endfunction

   function automatic stim_row_type with_result(input stim_row_type r, input bit acc,
                                                input logic [MAX_MOTORS-1:0] pins,
                                                input logic [MAX_MOTORS-1:0] en,
                                                input logic [LEVEL_W-1:0] lvl,
                                                input bit strm);
      stim_row_type p;
      p = r;
      p.pinned = 1'b1;
      p.want.push_accepted = acc;
      p.want.step_pins     = pins;
      p.want.motor_enables = en;
      p.want.queue_level   = lvl;
      p.want.streaming     = strm;
      return p;
   endfunction

   // frames are mostly short so the queue keeps moving
   function automatic stim_row_type random_push();
      logic [DUR_W-1:0] dur;
      dur = ($urandom_range(0, 7) == 0) ? DUR_W'($urandom_range(0, 40)) :
                                          DUR_W'($urandom_range(0, 3));
      return make_row(OP_PUSH, dur, random_speed(), random_speed(), random_speed(),
                      random_speed());
   endfunction

   // tick payload is ignored by the block, so it is fully random
   function automatic stim_row_type random_tick();
      return make_row(OP_TICK, DUR_W'($urandom), $urandom, $urandom, $urandom, $urandom);
   endfunction

   // send one request in bursts with random gaps, predict on acceptance
   task automatic send_request(input stim_row_type r);
      rsp_type predicted;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160) :
                                                    $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= r.cmd.op;
      req_bus.frame_duration <= r.cmd.duration;
      req_bus.speed_zero     <= r.cmd.speeds[0];
      req_bus.speed_one      <= r.cmd.speeds[1];
      req_bus.speed_two      <= r.cmd.speeds[2];
      req_bus.speed_three    <= r.cmd.speeds[3];
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_step_result(r.cmd);
      expected_results.push_back(r.pinned ? r.want : predicted);
      if (r.cmd.op == OP_PUSH)
         pushes_sent++;
      else
         ticks_sent++;
   endtask

   // hold off new requests until every result is back
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_start_level(input logic [LEVEL_W-1:0] lvl);
      pause_until_drained();
      csr_bus.valid       <= 1'b1;
      csr_bus.start_level <= lvl;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      start_level_q = lvl;
      level_writes++;
   endtask

   // mostly push a few frames then tick through them, some mixed noise
   task automatic run_random_phase(input int n);
      int done_items;
      int pause_at;
      int k;
      bit paused;
      done_items = 0;
      paused     = 1'b0;
      pause_at   = $urandom_range(10, n - 10);
      while (done_items < n) begin
         if (!paused && done_items >= pause_at) begin
            pause_until_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            k = $urandom_range(1, 8);
            repeat (k) send_request(random_push());
            done_items += k;
            k = $urandom_range(1, 24);
            repeat (k) send_request(random_tick());
            done_items += k;
         end else begin
            k = $urandom_range(1, 6);
            repeat (k)
               send_request($urandom_range(0, 1) ? random_tick() : random_push());
            done_items += k;
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $error("result with no request outstanding");
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            step_pulses += $countones(rsp_bus.step_pins);
            if (rsp_bus.push_accepted !== want.push_accepted) begin
               error_count++;
               $error("push_accepted: expected %0d, got %0d", want.push_accepted,
                      rsp_bus.push_accepted);
            end
            if (rsp_bus.step_pins !== want.step_pins) begin
               error_count++;
               $error("step_pins: expected %b, got %b", want.step_pins, rsp_bus.step_pins);
            end
            if (rsp_bus.motor_enables !== want.motor_enables) begin
               error_count++;
               $error("motor_enables: expected %b, got %b", want.motor_enables,
                      rsp_bus.motor_enables);
            end
            if (rsp_bus.queue_level !== want.queue_level) begin
               error_count++;
               $error("queue_level: expected %0d, got %0d", want.queue_level,
                      rsp_bus.queue_level);
            end
            if (rsp_bus.streaming !== want.streaming) begin
               error_count++;
               $error("streaming: expected %0d, got %0d", want.streaming, rsp_bus.streaming);
            end
         end
      end
   end

   // receiver stalls: open stretches, coin flips and slow drips
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 2));
         rx_mode_left <= $urandom_range(20, 120);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_bus.ready <= 1'b1;
         RX_COIN: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= (rx_mode_left % 6 == 0);
      endcase
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      stim_row_type       directed_table [$];
      stim_row_type       r;
      logic [LEVEL_W-1:0] phase_levels [8];
      int                 i;

      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_PUSH;
      req_bus.frame_duration = '0;
      req_bus.speed_zero     = '0;
      req_bus.speed_one      = '0;
      req_bus.speed_two      = '0;
      req_bus.speed_three    = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.start_level    = START_LEVEL_RESET;
      for (i = 0; i < MAX_MOTORS; i++) begin
         phase_acc[i]  = '0;
         live_speed[i] = '0;
      end

      // directed rows, start level 4 from reset
      directed_table.push_back(with_result(make_row(OP_TICK, '1, '1, '1, '1, '1),
                                           1'b0, 4'h0, 4'h0, 5'd0, 1'b0));
      directed_table.push_back(with_result(make_row(OP_PUSH, 16'd0, 32'hFFFF_FFFF,
                                           32'h8000_0000, 32'h1, 32'h0),
                                           1'b1, 4'h0, 4'h0, 5'd1, 1'b0));
      // below start level and not streaming: speeds stay zero
      directed_table.push_back(with_result(make_row(OP_TICK, '0, '0, '0, '0, '0),
                                           1'b0, 4'h0, 4'h0, 5'd1, 1'b0));
      directed_table.push_back(with_result(make_row(OP_PUSH, 16'd1, 32'hFFFF_FFFF,
                                           32'h8000_0000, 32'h7FFF_FFFF, 32'h0),
                                           1'b1, 4'h0, 4'h0, 5'd2, 1'b0));
      directed_table.push_back(with_result(make_row(OP_PUSH, 16'd2, 32'h0, 32'h0, 32'h0,
                                           32'hFFFF_FFFF),
                                           1'b1, 4'h0, 4'h0, 5'd3, 1'b0));
      directed_table.push_back(with_result(make_row(OP_PUSH, 16'd3, 32'h1, 32'h0, 32'h0,
                                           32'h0),
                                           1'b1, 4'h0, 4'h0, 5'd4, 1'b0));
      // start level reached: first frame loads, duration zero runs one tick
      directed_table.push_back(with_result(make_row(OP_TICK, '0, '0, '0, '0, '0),
                                           1'b0, 4'h0, 4'h7, 5'd3, 1'b1));
      // full-scale speeds wrap the accumulators
      directed_table.push_back(make_row(OP_TICK, '0, '0, '0, '0, '0));
      directed_table.push_back(make_row(OP_TICK, '1, '1, '1, '1, '1));
      for (i = 0; i < 15; i++)
         directed_table.push_back(random_push());
      // queue full: push rejected, pins and speeds untouched
      directed_table.push_back(make_row(OP_PUSH, '1, '1, '1, '1, '1));
      directed_table.push_back(make_row(OP_TICK, '0, '0, '0, '0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[j])
         send_request(directed_table[j]);

      // random phases over a range of start levels, extremes included
      phase_levels[0] = 5'd1;
      phase_levels[1] = 5'd16;
      phase_levels[2] = 5'd0;
      phase_levels[3] = 5'd9;
      phase_levels[4] = 5'd31;
      phase_levels[5] = 5'd17;
      phase_levels[6] = 5'd2;
      phase_levels[7] = LEVEL_W'($urandom_range(1, 16));
      for (i = 0; i < 8; i++) begin
         write_start_level(phase_levels[i]);
         run_random_phase(100);
         if (i == 2) begin
            // one long frame, ticked all the way through
            write_start_level(5'd1);
            while (queued_frames != 0 || frame_ticks_left != 0)
               send_request(random_tick());
            r = random_push();
            r.cmd.duration = 16'd120;
            send_request(r);
            while (queued_frames != 0 || frame_ticks_left != 0)
               send_request(random_tick());
            // empty queue ends streaming
            send_request(random_tick());
         end
      end

      // longest frame duration: load it and run the first ticks of it
      write_start_level(5'd1);
      while (queued_frames != 0 || frame_ticks_left != 0)
         send_request(random_tick());
      r = random_push();
      r.cmd.duration = '1;
      send_request(r);
      repeat (24) send_request(random_tick());

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (8) @(posedge clock);

      $display("summary: %0d pushes (%0d rejected on a full queue), %0d ticks, %0d results",
               pushes_sent, pushes_rejected, ticks_sent, results_checked);
      $display("summary: %0d step pulses seen, %0d start level writes, %0d mismatches",
               step_pulses, level_writes, error_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
